// ===== hw/rtl/cclw_pkg.sv =====
package cclw_pkg;

    localparam int KEY_W   = 24;
    localparam int TAG_W   = 8;
    localparam int DATA_W  = 64;
    localparam int VADDR_W = 48;
    localparam int PROD_W  = 37;
    localparam int PAGE_SH = 12;
    localparam logic [11:0] PAGE_MASK = 12'hfff;

    typedef logic [1:0] op_t;
    typedef logic [1:0] kind_t;

    localparam op_t OP_READ  = 2'd0;
    localparam op_t OP_WRITE = 2'd1;
    localparam op_t OP_FILL  = 2'd2;
    localparam op_t OP_MAP   = 2'd3;

    localparam kind_t KIND_ACK   = 2'd0;
    localparam kind_t KIND_RDATA = 2'd1;
    localparam kind_t KIND_FETCH = 2'd2;
    localparam kind_t KIND_WB    = 2'd3;

    localparam logic [1:0] CFG_ENTRIES = 2'd0;
    localparam logic [1:0] CFG_EBYTES  = 2'd1;
    localparam logic [1:0] CFG_BASE    = 2'd2;

endpackage

// ===== hw/rtl/context_cache_lru_writeback_core.sv =====
// Access: an access scans every entry before its first result is valid, and a miss that
// translates an address then runs a multiply, a page-table read and an add.
// Items: one item at a time; no new item is taken until the last one is done, and the scan
// runs through the single read port of the entry memory. Map items skip the scan.
// Reset: valid bits, occupancy, stamp counter and control state clear at once; configuration
// takes its defaults; entry and page-table memories are not cleared, so no clearing pass runs.
module context_cache_lru_writeback_core #(
    parameter int ENTRIES    = 64,
    parameter int PAGES      = 1024,
    parameter int VALUE_BITS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [47:0]                cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  cclw_pkg::op_t              op,
    input  logic [23:0]                resource_index,
    input  logic [63:0]                entry_value,
    input  logic [7:0]                 request_tag,
    input  logic [47:0]                page_vaddr,
    input  logic [63:0]                page_paddr,
    output logic                       out_valid,
    input  logic                       out_ready,
    output cclw_pkg::kind_t            kind,
    output logic [63:0]                mem_address,
    output logic [63:0]                data_out,
    output logic [23:0]                index_out,
    output logic [7:0]                 tag_out,
    output logic                       last
);
    import cclw_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CW    = (CNT_W > 7) ? CNT_W : 7;
    localparam int PG_W  = $clog2(PAGES);
    localparam int EW    = KEY_W + VALUE_BITS + 64;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MAP   = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_DEC   = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_PT    = 4'd5;
    localparam logic [3:0] S_PTQ   = 4'd6;
    localparam logic [3:0] S_XOUT  = 4'd7;
    localparam logic [3:0] S_FINAL = 4'd8;

    logic [3:0] state_reg;
    logic [6:0] eiu_reg;
    logic [12:0] eb_reg;
    logic [VADDR_W-1:0] base_reg;

    op_t op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [VADDR_W-1:0] pv_reg;
    logic [63:0] pp_reg;

    logic [ENTRIES-1:0] valid_bits_reg;
    logic [CNT_W-1:0] occ_reg;
    logic [63:0] stamp_reg;

    logic [CNT_W-1:0] scan_reg;
    logic pend_reg;
    logic [IDX_W-1:0] rslot_reg;
    logic hit_reg, free_reg, vic_reg;
    logic [IDX_W-1:0] hit_slot_reg, free_slot_reg, vic_slot_reg;
    logic [VALUE_BITS-1:0] hit_val_reg, vic_val_reg;
    logic [KEY_W-1:0] vic_key_reg;
    logic [63:0] best_reg;

    logic wb_reg;
    logic [KEY_W-1:0] xkey_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [63:0] addr_reg;
    kind_t fin_kind_reg;
    logic [VALUE_BITS-1:0] fin_data_reg;
    logic [KEY_W-1:0] fin_idx_reg;

    logic out_valid_reg;
    kind_t kind_reg;
    logic [63:0] maddr_reg, dout_reg;
    logic [KEY_W-1:0] iout_reg;
    logic [TAG_W-1:0] tout_reg;
    logic last_reg;

    // entry memory port
    logic e_we;
    logic [IDX_W-1:0] e_waddr;
    logic [EW-1:0] e_wdata, e_q;
    logic [KEY_W-1:0] q_key;
    logic [VALUE_BITS-1:0] q_val;
    logic [63:0] q_stamp;

    logic p_we;
    logic [PG_W-1:0] p_waddr, p_raddr;
    logic [63:0] p_q;

    logic [CW-1:0] cap;
    logic out_free;
    logic [VADDR_W-1:0] rel;
    logic [VADDR_W-PAGE_SH-1:0] map_page;
    logic map_ok;
    logic [PROD_W-PAGE_SH-1:0] x_page;
    logic x_ok;
    logic q_match;

    assign q_key   = e_q[EW-1 -: KEY_W];
    assign q_val   = e_q[64 +: VALUE_BITS];
    assign q_stamp = e_q[63:0];
    assign q_match = valid_bits_reg[rslot_reg] && (q_key == key_reg);

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        if (eiu_reg == 7'd0)
            cap = CW'(1);
        else if (CW'(eiu_reg) > CW'(ENTRIES))
            cap = CW'(ENTRIES);
        else
            cap = CW'(eiu_reg);
    end

    assign rel      = pv_reg - base_reg;
    assign map_page = rel[VADDR_W-1:PAGE_SH];
    assign map_ok   = ({1'b0, map_page} < (VADDR_W - PAGE_SH + 1)'(PAGES));
    assign x_page   = prod_reg[PROD_W-1:PAGE_SH];
    assign x_ok     = ({1'b0, x_page} < (PROD_W - PAGE_SH + 1)'(PAGES));
    assign p_raddr  = x_page[PG_W-1:0];
    assign p_waddr  = map_page[PG_W-1:0];
    assign p_we     = (state_reg == S_MAP) && map_ok;

    always_comb
    begin
        e_we    = 1'b0;
        e_waddr = hit_slot_reg;
        e_wdata = {key_reg, val_reg, stamp_reg};
        if (state_reg == S_DEC && op_reg != OP_READ)
        begin
            if (hit_reg)
            begin
                e_we    = 1'b1;
                e_wdata = {key_reg, (op_reg == OP_WRITE) ? val_reg : hit_val_reg, stamp_reg};
            end
            else if (CW'(occ_reg) < cap)
            begin
                e_we    = 1'b1;
                e_waddr = free_slot_reg;
            end
        end
        else if (state_reg == S_DEC && hit_reg)
        begin
            e_we    = 1'b1;
            e_wdata = {key_reg, hit_val_reg, stamp_reg};
        end
        else if (state_reg == S_XOUT && wb_reg && out_free)
        begin
            e_we    = 1'b1;
            e_waddr = vic_slot_reg;
        end
    end

    cclw_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_entry_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (scan_reg[IDX_W-1:0]),
        .rdata (e_q)
    );

    cclw_ram #(.WIDTH(64), .DEPTH(PAGES)) u_page_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (pp_reg),
        .raddr (p_raddr),
        .rdata (p_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eiu_reg  <= 7'd64;
            eb_reg   <= 13'd64;
            base_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENTRIES: eiu_reg  <= cfg_data[6:0];
                CFG_EBYTES:  eb_reg   <= cfg_data[12:0];
                CFG_BASE:    base_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_bits_reg <= '0;
            occ_reg        <= '0;
            stamp_reg      <= '0;
            scan_reg       <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // the output states load the next beat themselves when the register frees up
            if (out_valid_reg && out_ready && state_reg != S_XOUT && state_reg != S_FINAL)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg   <= op;
                        key_reg  <= resource_index;
                        val_reg  <= entry_value[VALUE_BITS-1:0];
                        tag_reg  <= request_tag;
                        pv_reg   <= page_vaddr;
                        pp_reg   <= page_paddr;
                        scan_reg <= '0;
                        pend_reg <= 1'b0;
                        hit_reg  <= 1'b0;
                        free_reg <= 1'b0;
                        vic_reg  <= 1'b0;
                        state_reg <= (op == OP_MAP) ? S_MAP : S_SCAN;
                    end
                end
                S_MAP:
                begin
                    fin_kind_reg <= KIND_ACK;
                    fin_data_reg <= '0;
                    fin_idx_reg  <= '0;
                    state_reg    <= S_FINAL;
                end
                S_SCAN:
                begin
                    // issue one read a cycle, evaluate the entry read last cycle
                    pend_reg  <= (scan_reg < CNT_W'(ENTRIES));
                    rslot_reg <= scan_reg[IDX_W-1:0];
                    if (scan_reg < CNT_W'(ENTRIES))
                        scan_reg <= scan_reg + CNT_W'(1);
                    if (pend_reg)
                    begin
                        if (q_match && !hit_reg)
                        begin
                            hit_reg      <= 1'b1;
                            hit_slot_reg <= rslot_reg;
                            hit_val_reg  <= q_val;
                        end
                        if (!valid_bits_reg[rslot_reg] && !free_reg)
                        begin
                            free_reg      <= 1'b1;
                            free_slot_reg <= rslot_reg;
                        end
                        if (valid_bits_reg[rslot_reg] && (!vic_reg || q_stamp < best_reg))
                        begin
                            vic_reg      <= 1'b1;
                            best_reg     <= q_stamp;
                            vic_slot_reg <= rslot_reg;
                            vic_key_reg  <= q_key;
                            vic_val_reg  <= q_val;
                        end
                    end
                    if (!pend_reg && scan_reg == CNT_W'(ENTRIES))
                        state_reg <= S_DEC;
                end
                S_DEC:
                begin
                    fin_idx_reg <= key_reg;
                    fin_kind_reg <= (op_reg == OP_WRITE) ? KIND_ACK : KIND_RDATA;
                    if (hit_reg)
                    begin
                        fin_data_reg <= (op_reg == OP_WRITE) ? '0 : hit_val_reg;
                        stamp_reg    <= stamp_reg + 64'd1;
                        state_reg    <= S_FINAL;
                    end
                    else if (op_reg == OP_READ)
                    begin
                        wb_reg    <= 1'b0;
                        xkey_reg  <= key_reg;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        fin_data_reg <= (op_reg == OP_WRITE) ? '0 : val_reg;
                        if (CW'(occ_reg) < cap)
                        begin
                            valid_bits_reg[free_slot_reg] <= 1'b1;
                            occ_reg   <= occ_reg + CNT_W'(1);
                            stamp_reg <= stamp_reg + 64'd1;
                            state_reg <= S_FINAL;
                        end
                        else
                        begin
                            wb_reg    <= 1'b1;
                            xkey_reg  <= vic_key_reg;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= PROD_W'(xkey_reg) * PROD_W'(eb_reg);
                    state_reg <= S_PT;
                end
                S_PT:
                begin
                    state_reg <= S_PTQ;
                end
                S_PTQ:
                begin
                    addr_reg  <= (x_ok ? p_q : 64'd0) + 64'(prod_reg[PAGE_SH-1:0] & PAGE_MASK);
                    state_reg <= S_XOUT;
                end
                S_XOUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        maddr_reg     <= addr_reg;
                        if (wb_reg)
                        begin
                            kind_reg  <= KIND_WB;
                            dout_reg  <= 64'(vic_val_reg);
                            iout_reg  <= vic_key_reg;
                            tout_reg  <= '0;
                            last_reg  <= 1'b0;
                            // victim slot is reused in place: valid stays set
                            stamp_reg <= stamp_reg + 64'd1;
                            state_reg <= S_FINAL;
                        end
                        else
                        begin
                            kind_reg  <= KIND_FETCH;
                            dout_reg  <= '0;
                            iout_reg  <= key_reg;
                            tout_reg  <= tag_reg;
                            last_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_FINAL:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        kind_reg      <= fin_kind_reg;
                        maddr_reg     <= '0;
                        dout_reg      <= 64'(fin_data_reg);
                        iout_reg      <= fin_idx_reg;
                        tout_reg      <= tag_reg;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign mem_address = maddr_reg;
    assign data_out    = dout_reg;
    assign index_out   = iout_reg;
    assign tag_out     = tout_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(ENTRIES))
        else $error("occupancy above entry count");

    a_occ_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_bits_reg) == int'(occ_reg))
        else $error("occupancy does not match valid entries");

    a_wb_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_WB |-> !last_reg)
        else $error("writeback marked as final beat");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(e_we && state_reg == S_SCAN))
        else $error("entry write during scan");
`endif

endmodule

// ===== hw/rtl/cclw_ram.sv =====
module cclw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
